// File: rtl/core/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Types, widths, register map and plane tables of the frustum box cull block.
// ----------------------------------------------------------------------------
package fbc_pkg;

   localparam int PLANE_MAX   = 6;
   localparam int PLANE_COUNT = 6;   // 1 .. PLANE_MAX
   localparam int COORD_WIDTH = 32;  // 16 .. IN_W
   localparam int IN_W        = 32;
   localparam int ELEM_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int AXES        = 3;
   localparam int COEF_N      = 4;

   localparam int COEF_W = ELEM_W + 1;
   localparam int PROD_W = COEF_W + COORD_WIDTH;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   // configuration register map
   localparam int CSR_COUNT  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_LSB    = 3;
   localparam int CSR_ADDR_W = CSR_IDX_W + CSR_LSB;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_COL0_ROWS01 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL0_ROWS23 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL1_ROWS01 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL1_ROWS23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COL2_ROWS01 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COL2_ROWS23 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COL3_ROWS01 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COL3_ROWS23 = 3'd7;

   // identity matrix
   localparam logic [CSR_DATA_W-1:0] CSR_RESET [CSR_COUNT] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
   localparam logic [1:0] VERDICT_PARTLY  = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

   // left, right, top, bottom, near, far
   localparam int   PLANE_ROW  [PLANE_MAX] = '{0, 0, 1, 1, 2, 2};
   localparam logic PLANE_NEG  [PLANE_MAX] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
   localparam logic PLANE_BASE [PLANE_MAX] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

   typedef logic signed [ELEM_W-1:0]      elem_type;
   typedef elem_type [3:0]                mat_col_type;
   typedef mat_col_type [3:0]             mat_type;     // [col][row]
   typedef logic signed [COEF_W-1:0]      coef_type;
   typedef coef_type [COEF_N-1:0]         coef_vec_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef coord_type [AXES-1:0]          point_type;

   typedef struct packed {
      logic mul;
      logic sum;
      logic sgn;
   } ld_type;

   // plane k coefficients: row 3 plus or minus the plane's row, or that row alone where PLANE_BASE is clear
   function automatic coef_vec_type fbc_coef(input mat_type m, input int k);
      coef_vec_type r;
      coef_type     e;
      coef_type     b;
      int           c;
      for (c = 0; c < COEF_N; c++) begin
         e = COEF_W'(m[c][PLANE_ROW[k]]);
         b = PLANE_BASE[k] ? COEF_W'(m[c][3]) : '0;
         r[c] = PLANE_NEG[k] ? b - e : b + e;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/fbc_if.sv
// ----------------------------------------------------------------------------
// fbc_if
// Valid/ready channels of the frustum box cull block: box in, verdict out.
// ----------------------------------------------------------------------------
interface fbc_req_if import fbc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] min_x;
   logic [IN_W-1:0] min_y;
   logic [IN_W-1:0] min_z;
   logic [IN_W-1:0] max_x;
   logic [IN_W-1:0] max_y;
   logic [IN_W-1:0] max_z;

   modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
   modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface fbc_rsp_if import fbc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, verdict, input ready);
   modport sink   (input valid, verdict, output ready);
endinterface

// File: rtl/core/fbc_plane.sv
// ----------------------------------------------------------------------------
// fbc_plane
// One frustum plane: picks the positive and negative box corners and tells,
// three register stages later, whether each lies behind the plane.
// ----------------------------------------------------------------------------
module fbc_plane import fbc_pkg::*; (
   input  logic         clock,
   input  ld_type       ld,
   input  coef_vec_type coef,
   input  point_type    box_lo,
   input  point_type    box_hi,
   output logic         behind_p,
   output logic         behind_n
);

   coef_vec_type coef_ff;
   point_type    pv;
   point_type    nv;

   logic signed [PROD_W-1:0] prod_p_ff [AXES];
   logic signed [PROD_W-1:0] prod_n_ff [AXES];
   logic signed [PROD_W-1:0] prod_p_in [AXES];
   logic signed [PROD_W-1:0] prod_n_in [AXES];
   logic signed [PROD_W-1:0] cst_ff;
   logic signed [PROD_W-1:0] cst_in;

   logic signed [PAIR_W-1:0] pa_p_ff, pb_p_ff, pa_n_ff, pb_n_ff;
   logic signed [PAIR_W-1:0] pa_p_in, pb_p_in, pa_n_in, pb_n_in;
   logic signed [SUM_W-1:0]  tot_p, tot_n;
   logic                     behind_p_ff, behind_n_ff;

   // coefficients must change only while the pipe is empty; the block does not enforce it
   always_ff @(posedge clock) begin
      coef_ff <= coef;
   end

   always_comb begin
      for (int c = 0; c < AXES; c++) begin
         pv[c] = coef_ff[c][COEF_W-1] ? box_lo[c] : box_hi[c];
         nv[c] = coef_ff[c][COEF_W-1] ? box_hi[c] : box_lo[c];
         prod_p_in[c] = PROD_W'(coef_ff[c]) * PROD_W'(pv[c]);
         prod_n_in[c] = PROD_W'(coef_ff[c]) * PROD_W'(nv[c]);
      end
      cst_in = PROD_W'(coef_ff[COEF_N-1]) <<< FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (ld.mul) begin
         for (int c = 0; c < AXES; c++) begin
            prod_p_ff[c] <= prod_p_in[c];
            prod_n_ff[c] <= prod_n_in[c];
         end
         cst_ff <= cst_in;
      end
   end

   assign pa_p_in = PAIR_W'(prod_p_ff[0]) + PAIR_W'(prod_p_ff[1]);
   assign pb_p_in = PAIR_W'(prod_p_ff[2]) + PAIR_W'(cst_ff);
   assign pa_n_in = PAIR_W'(prod_n_ff[0]) + PAIR_W'(prod_n_ff[1]);
   assign pb_n_in = PAIR_W'(prod_n_ff[2]) + PAIR_W'(cst_ff);

   always_ff @(posedge clock) begin
      if (ld.sum) begin
         pa_p_ff <= pa_p_in;
         pb_p_ff <= pb_p_in;
         pa_n_ff <= pa_n_in;
         pb_n_ff <= pb_n_in;
      end
   end

   assign tot_p = SUM_W'(pa_p_ff) + SUM_W'(pb_p_ff);
   assign tot_n = SUM_W'(pa_n_ff) + SUM_W'(pb_n_ff);

   // zero distance counts as inside
   always_ff @(posedge clock) begin
      if (ld.sgn) begin
         behind_p_ff <= tot_p[SUM_W-1];
         behind_n_ff <= tot_n[SUM_W-1];
      end
   end

   assign behind_p = behind_p_ff;
   assign behind_n = behind_n_ff;

endmodule

// File: rtl/core/frustum_box_cull.sv
// ----------------------------------------------------------------------------
// frustum_box_cull
// Classifies axis-aligned boxes against the six planes of a view frustum.
// ----------------------------------------------------------------------------
// Takes one box per cycle unless a stalled result fills all stages; returns its
// verdict (outside, partly inside, inside) through a box register, a stage of
// 33x32 signed multipliers (three per corner, two corners per plane), two adder
// stages that finish each signed distance, and the verdict register. The
// matrix is written through the csr_ port (register i at byte address 8*i) and
// the plane coefficients are derived from it; write it only while no box is in
// flight. A stalled result does not block input until all stages are full.
module frustum_box_cull import fbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fbc_req_if.sink               req_if,
   fbc_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CSR_DATA_W-1:0] cfg_ff [CSR_COUNT];
   logic [CSR_IDX_W-1:0]  csr_idx;
   mat_type               mat;

   logic      v_box_ff, v_mul_ff, v_sum_ff, v_sgn_ff, v_out_ff;
   logic      adv_box, adv_mul, adv_sum, adv_sgn, adv_out;
   point_type lo_ff, hi_ff;
   ld_type    ld;
   logic [PLANE_COUNT-1:0] behind_p, behind_n;
   logic [1:0] verdict_ff, verdict_in;

   // ---------------- configuration ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_LSB];
   assign csr_prdata = cfg_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            cfg_ff[i] <= CSR_RESET[i];
         end
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         cfg_ff[csr_idx] <= csr_pwdata;
      end
   end

   assign mat[0][0] = cfg_ff[CSR_COL0_ROWS01][ELEM_W-1:0];
   assign mat[0][1] = cfg_ff[CSR_COL0_ROWS01][2*ELEM_W-1:ELEM_W];
   assign mat[0][2] = cfg_ff[CSR_COL0_ROWS23][ELEM_W-1:0];
   assign mat[0][3] = cfg_ff[CSR_COL0_ROWS23][2*ELEM_W-1:ELEM_W];
   assign mat[1][0] = cfg_ff[CSR_COL1_ROWS01][ELEM_W-1:0];
   assign mat[1][1] = cfg_ff[CSR_COL1_ROWS01][2*ELEM_W-1:ELEM_W];
   assign mat[1][2] = cfg_ff[CSR_COL1_ROWS23][ELEM_W-1:0];
   assign mat[1][3] = cfg_ff[CSR_COL1_ROWS23][2*ELEM_W-1:ELEM_W];
   assign mat[2][0] = cfg_ff[CSR_COL2_ROWS01][ELEM_W-1:0];
   assign mat[2][1] = cfg_ff[CSR_COL2_ROWS01][2*ELEM_W-1:ELEM_W];
   assign mat[2][2] = cfg_ff[CSR_COL2_ROWS23][ELEM_W-1:0];
   assign mat[2][3] = cfg_ff[CSR_COL2_ROWS23][2*ELEM_W-1:ELEM_W];
   assign mat[3][0] = cfg_ff[CSR_COL3_ROWS01][ELEM_W-1:0];
   assign mat[3][1] = cfg_ff[CSR_COL3_ROWS01][2*ELEM_W-1:ELEM_W];
   assign mat[3][2] = cfg_ff[CSR_COL3_ROWS23][ELEM_W-1:0];
   assign mat[3][3] = cfg_ff[CSR_COL3_ROWS23][2*ELEM_W-1:ELEM_W];

   // ---------------- pipeline control ----------------
   // a stage moves when it is empty or the next one moves
   assign adv_out = !v_out_ff || rsp_if.ready;
   assign adv_sgn = !v_sgn_ff || adv_out;
   assign adv_sum = !v_sum_ff || adv_sgn;
   assign adv_mul = !v_mul_ff || adv_sum;
   assign adv_box = !v_box_ff || adv_mul;

   assign req_if.ready = adv_box;

   assign ld.mul = adv_mul && v_box_ff;
   assign ld.sum = adv_sum && v_mul_ff;
   assign ld.sgn = adv_sgn && v_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_box_ff <= 1'b0;
         v_mul_ff <= 1'b0;
         v_sum_ff <= 1'b0;
         v_sgn_ff <= 1'b0;
         v_out_ff <= 1'b0;
      end else begin
         if (adv_box) begin
            v_box_ff <= req_if.valid;
         end
         if (adv_mul) begin
            v_mul_ff <= v_box_ff;
         end
         if (adv_sum) begin
            v_sum_ff <= v_mul_ff;
         end
         if (adv_sgn) begin
            v_sgn_ff <= v_sum_ff;
         end
         if (adv_out) begin
            v_out_ff <= v_sgn_ff;
         end
      end
   end

   // ---------------- box register ----------------
   always_ff @(posedge clock) begin
      if (adv_box && req_if.valid) begin
         lo_ff[0] <= req_if.min_x[COORD_WIDTH-1:0];
         lo_ff[1] <= req_if.min_y[COORD_WIDTH-1:0];
         lo_ff[2] <= req_if.min_z[COORD_WIDTH-1:0];
         hi_ff[0] <= req_if.max_x[COORD_WIDTH-1:0];
         hi_ff[1] <= req_if.max_y[COORD_WIDTH-1:0];
         hi_ff[2] <= req_if.max_z[COORD_WIDTH-1:0];
      end
   end

   // ---------------- planes ----------------
   for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
      fbc_plane u_plane (
         .clock    (clock),
         .ld       (ld),
         .coef     (fbc_coef(mat, k)),
         .box_lo   (lo_ff),
         .box_hi   (hi_ff),
         .behind_p (behind_p[k]),
         .behind_n (behind_n[k])
      );
   end

   // ---------------- verdict ----------------
   always_comb begin
      if (|behind_p) begin
         verdict_in = VERDICT_OUTSIDE;
      end else if (|behind_n) begin
         verdict_in = VERDICT_PARTLY;
      end else begin
         verdict_in = VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && v_sgn_ff) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_if.valid   = v_out_ff;
   assign rsp_if.verdict = verdict_ff;

   // ---------------- assertions ----------------
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.verdict == VERDICT_OUTSIDE ||
                        rsp_if.verdict == VERDICT_PARTLY ||
                        rsp_if.verdict == VERDICT_INSIDE))
      else $error("verdict code out of range");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (v_sgn_ff && adv_out) |=> v_out_ff)
      else $error("item lost between sign and output stage");

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !(v_box_ff && v_mul_ff && v_sum_ff && v_sgn_ff && v_out_ff) |-> req_if.ready)
      else $error("input stalled while the pipe has a free stage");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_if.valid)
      else $error("result valid right after reset");

endmodule
